[rtl/ogu_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and codes of the occupancy grid update block.
package ogu_pkg;

   localparam int MAX_ROWS   = 256;
   localparam int MAX_COLS   = 256;
   localparam int CELL_STORE = MAX_ROWS * MAX_COLS;
   localparam int CELL_AW    = (CELL_STORE > 1) ? $clog2(CELL_STORE) : 1;
   localparam int CNT_W      = CELL_AW + 1;
   localparam int ROW_W      = $clog2(MAX_ROWS + 1);
   localparam int COL_W      = $clog2(MAX_COLS + 1);
   localparam int PROD_W     = ROW_W + COL_W;
   localparam int CSR_IDX_W  = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] FUNC_UPDATE = 2'd0;
   localparam logic [1:0] FUNC_RESET  = 2'd1;

   localparam logic [2:0] ST_UPDATED    = 3'd0;
   localparam logic [2:0] ST_OUTSIDE    = 3'd1;
   localparam logic [2:0] ST_LOCKED     = 3'd2;
   localparam logic [2:0] ST_RESET_DONE = 3'd3;
   localparam logic [2:0] ST_CLEARED    = 3'd4;

   localparam logic [1:0] CLS_FREE     = 2'd0;
   localparam logic [1:0] CLS_UNKNOWN  = 2'd1;
   localparam logic [1:0] CLS_OCCUPIED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FLOOR      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CEILING    = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OCC_LOCK   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FREE_LOCK  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FREE_THR   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_OCC_THR    = 4'd7;

   typedef enum logic [1:0] {
      OP_UPDATE,
      OP_OUTSIDE,
      OP_RESET,
      OP_CLEAR
   } op_type;

   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_READ,
      BK_CALC,
      BK_SWEEP,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [8:0]         grid_cols;
      logic [8:0]         grid_rows;
      logic signed [15:0] floor_lvl;
      logic signed [15:0] ceil_lvl;
      logic signed [15:0] occ_lock;
      logic signed [15:0] free_lock;
      logic signed [15:0] free_thr;
      logic signed [15:0] occ_thr;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] logodds;
      logic [1:0]         cls;
      logic               lock;
      logic               dirty;
   } cell_type;

   typedef struct packed {
      op_type               op;
      logic [CELL_AW-1:0]   idx;
      logic signed [15:0]   delta;
      logic                 unlock_all;
      logic [CNT_W-1:0]     cells;
   } work_type;

endpackage

[rtl/ogu_req_if.sv]
`timescale 1ns / 1ps
// Command channel carrying one grid command word.
interface ogu_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [15:0] row;
   logic signed [15:0] col;
   logic signed [15:0] delta;
   logic               unlock_all;

   modport source (output valid, func, row, col, delta, unlock_all, input ready);
   modport sink (input valid, func, row, col, delta, unlock_all, output ready);
endinterface

[rtl/ogu_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel carrying one status word per command.
interface ogu_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [15:0] new_logodds;
   logic [1:0]         new_class;
   logic               now_locked;
   logic               class_changed;
   logic [16:0]        dirty_count;
   logic               map_changed;
   logic               free_set_stale;
   logic               likelihood_stale;
   logic [31:0]        occupied_change_count;

   modport source (output valid, status, new_logodds, new_class, now_locked,
                   class_changed, dirty_count, map_changed, free_set_stale,
                   likelihood_stale, occupied_change_count, input ready);
   modport sink (input valid, status, new_logodds, new_class, now_locked,
                 class_changed, dirty_count, map_changed, free_set_stale,
                 likelihood_stale, occupied_change_count, output ready);
endinterface

[rtl/ogu_csr_if.sv]
`timescale 1ns / 1ps
// Register write channel.
interface ogu_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/ogu_queue.sv]
`timescale 1ns / 1ps
// Short work queue between the command front end and the cell engine.
module ogu_queue
   import ogu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output work_type pop_data
);

   work_type   slot_ff [QUEUE_DEPTH];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == 2'(QUEUE_DEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rptr_ff];

endmodule

[rtl/ogu_front.sv]
`timescale 1ns / 1ps
// Command front end: bounds check, cell index and in-use cell count.
module ogu_front
   import ogu_pkg::*;
(
   ogu_req_if.sink     req,
   input  cfg_type     cfg,
   input  logic        q_full,
   input  logic        init_busy,
   output logic        push,
   output work_type    push_data
);

   logic [ROW_W-1:0]  nr;
   logic [COL_W-1:0]  nc;
   logic              in_grid;
   logic [ROW_W-1:0]  mul_a;
   logic [PROD_W-1:0] prod;

   always_comb begin
      nr = ROW_W'((32'(cfg.grid_rows) < MAX_ROWS) ? 32'(cfg.grid_rows) : MAX_ROWS);
      nc = COL_W'((32'(cfg.grid_cols) < MAX_COLS) ? 32'(cfg.grid_cols) : MAX_COLS);
      in_grid = !req.row[15] && !req.col[15] &&
                (req.row < $signed(16'(nr))) && (req.col < $signed(16'(nc)));
      // One multiplier serves both the cell index and the reset cell count.
      mul_a = (req.func == FUNC_RESET) ? nr : ROW_W'(req.row);
      prod  = PROD_W'(mul_a) * PROD_W'(nc);

      push_data.idx        = CELL_AW'(prod + PROD_W'(req.col));
      push_data.delta      = req.delta;
      push_data.unlock_all = req.unlock_all;
      push_data.cells      = CNT_W'(prod);
      unique case (req.func)
         FUNC_UPDATE: push_data.op = in_grid ? OP_UPDATE : OP_OUTSIDE;
         FUNC_RESET:  push_data.op = OP_RESET;
         default:     push_data.op = OP_CLEAR;
      endcase
   end

   assign req.ready = !q_full && !init_busy;
   assign push      = req.valid && req.ready;

endmodule

[rtl/ogu_back.sv]
`timescale 1ns / 1ps
// Cell engine: cell memory read-modify-write, map sweeps and result register.
module ogu_back
   import ogu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      q_valid,
   input  work_type  q_data,
   output logic      q_pop,
   output logic      init_busy,
   ogu_rsp_if.source rsp
);

   cell_type           cell_mem [CELL_STORE];
   logic [CELL_AW-1:0] dlist_mem [CELL_STORE];

   back_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   work_type           work_ff, work_in;
   cell_type           rdata_ff;
   logic [CNT_W-1:0]   dlen_ff, dlen_in;
   logic               map_ff, map_in;
   logic               free_ff, free_in;
   logic               lik_ff, lik_in;
   logic [31:0]        occ_ff, occ_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         status_ff, status_in;
   logic signed [15:0] lo_ff, lo_in;
   logic [1:0]         cls_ff, cls_in;
   logic               locked_ff, locked_in;
   logic               chg_ff, chg_in;

   logic               rd_en, wr_en, dl_wr_en;
   logic [CELL_AW-1:0] rd_addr, wr_addr, dl_wr_addr, dl_wr_data;
   cell_type           wr_data;

   logic               out_free;
   logic [CNT_W-1:0]   widx;
   logic signed [16:0] sum;
   logic signed [15:0] sat;
   logic [1:0]         new_cls;
   logic               new_lock;
   logic               changed;

   always_comb begin
      out_free = !rsp_valid_ff || rsp.ready;
      widx     = cnt_ff - CNT_W'(1);

      // Saturate to the ceiling first, then the floor, so the floor wins.
      sum = $signed({rdata_ff.logodds[15], rdata_ff.logodds}) +
            $signed({work_ff.delta[15], work_ff.delta});
      if (sum > $signed({cfg.ceil_lvl[15], cfg.ceil_lvl})) begin
         sum = $signed({cfg.ceil_lvl[15], cfg.ceil_lvl});
      end
      if (sum < $signed({cfg.floor_lvl[15], cfg.floor_lvl})) begin
         sum = $signed({cfg.floor_lvl[15], cfg.floor_lvl});
      end
      sat = sum[15:0];
      if (sat < cfg.free_thr) begin
         new_cls = CLS_FREE;
      end else if (sat > cfg.occ_thr) begin
         new_cls = CLS_OCCUPIED;
      end else begin
         new_cls = CLS_UNKNOWN;
      end
      new_lock = (sat >= cfg.occ_lock) || (sat <= cfg.free_lock);
      changed  = (new_cls != rdata_ff.cls);

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      work_in      = work_ff;
      dlen_in      = dlen_ff;
      map_in       = map_ff;
      free_in      = free_ff;
      lik_in       = lik_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      lo_in        = lo_ff;
      cls_in       = cls_ff;
      locked_in    = locked_ff;
      chg_in       = chg_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = work_ff.idx;
      wr_en        = 1'b0;
      wr_addr      = work_ff.idx;
      wr_data      = rdata_ff;
      dl_wr_en     = 1'b0;
      dl_wr_addr   = dlen_ff[CELL_AW-1:0];
      dl_wr_data   = work_ff.idx;

      unique case (state_ff)
         BK_INIT: begin
            wr_en           = 1'b1;
            wr_addr         = cnt_ff[CELL_AW-1:0];
            wr_data.logodds = '0;
            wr_data.cls     = CLS_UNKNOWN;
            wr_data.lock    = 1'b0;
            wr_data.dirty   = 1'b0;
            cnt_in          = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CELL_STORE - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               work_in = q_data;
               cnt_in  = '0;
               unique case (q_data.op)
                  OP_UPDATE:  state_in = BK_READ;
                  OP_OUTSIDE: state_in = BK_DONE;
                  default:    state_in = BK_SWEEP;
               endcase
            end
         end
         BK_READ: begin
            rd_en    = 1'b1;
            state_in = BK_CALC;
         end
         BK_CALC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               chg_in       = 1'b0;
               state_in     = BK_IDLE;
               if (rdata_ff.lock) begin
                  status_in = ST_LOCKED;
                  lo_in     = rdata_ff.logodds;
                  cls_in    = rdata_ff.cls;
                  locked_in = 1'b1;
               end else begin
                  wr_en           = 1'b1;
                  wr_data.logodds = sat;
                  wr_data.cls     = new_cls;
                  wr_data.lock    = new_lock;
                  status_in       = ST_UPDATED;
                  lo_in           = sat;
                  cls_in          = new_cls;
                  locked_in       = new_lock;
                  chg_in          = changed;
                  if (changed) begin
                     map_in = 1'b1;
                     if (!rdata_ff.dirty && (dlen_ff < CNT_W'(CELL_STORE))) begin
                        wr_data.dirty = 1'b1;
                        dl_wr_en      = 1'b1;
                        dlen_in       = dlen_ff + CNT_W'(1);
                     end
                     if ((rdata_ff.cls == CLS_FREE) || (new_cls == CLS_FREE)) begin
                        free_in = 1'b1;
                     end
                     if ((rdata_ff.cls == CLS_OCCUPIED) || (new_cls == CLS_OCCUPIED)) begin
                        lik_in = 1'b1;
                        if (occ_ff != '1) begin
                           occ_in = occ_ff + 32'd1;
                        end
                     end
                  end
               end
            end
         end
         BK_SWEEP: begin
            // Read entry cnt while writing back entry cnt-1.
            rd_en   = (cnt_ff != CNT_W'(CELL_STORE));
            rd_addr = cnt_ff[CELL_AW-1:0];
            wr_addr = widx[CELL_AW-1:0];
            if (work_ff.op == OP_RESET) begin
               wr_data.logodds = '0;
               wr_data.cls     = CLS_UNKNOWN;
               wr_data.lock    = rdata_ff.lock && !work_ff.unlock_all;
               wr_data.dirty   = (widx < work_ff.cells);
               dl_wr_addr      = widx[CELL_AW-1:0];
               dl_wr_data      = widx[CELL_AW-1:0];
               dl_wr_en        = (cnt_ff != '0) && (widx < work_ff.cells);
            end else begin
               wr_data.dirty = 1'b0;
            end
            wr_en = (cnt_ff != '0);
            if (cnt_ff == CNT_W'(CELL_STORE)) begin
               state_in = BK_DONE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               lo_in        = '0;
               cls_in       = '0;
               locked_in    = 1'b0;
               chg_in       = 1'b0;
               state_in     = BK_IDLE;
               unique case (work_ff.op)
                  OP_RESET: begin
                     status_in = ST_RESET_DONE;
                     dlen_in   = work_ff.cells;
                     map_in    = 1'b1;
                     free_in   = 1'b1;
                     lik_in    = 1'b1;
                     occ_in    = 32'(work_ff.cells);
                  end
                  OP_CLEAR: begin
                     status_in = ST_CLEARED;
                     dlen_in   = '0;
                  end
                  default: status_in = ST_OUTSIDE;
               endcase
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_INIT;
         cnt_ff       <= '0;
         dlen_ff      <= '0;
         map_ff       <= 1'b1;
         free_ff      <= 1'b1;
         lik_ff       <= 1'b1;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dlen_ff      <= dlen_in;
         map_ff       <= map_in;
         free_ff      <= free_in;
         lik_ff       <= lik_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      status_ff <= status_in;
      lo_ff     <= lo_in;
      cls_ff    <= cls_in;
      locked_ff <= locked_in;
      chg_ff    <= chg_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= cell_mem[rd_addr];
      end
      if (dl_wr_en) begin
         dlist_mem[dl_wr_addr] <= dl_wr_data;
      end
   end

   assign init_busy                 = (state_ff == BK_INIT);
   assign rsp.valid                 = rsp_valid_ff;
   assign rsp.status                = status_ff;
   assign rsp.new_logodds           = lo_ff;
   assign rsp.new_class             = cls_ff;
   assign rsp.now_locked            = locked_ff;
   assign rsp.class_changed         = chg_ff;
   assign rsp.dirty_count           = 17'(dlen_ff);
   assign rsp.map_changed           = map_ff;
   assign rsp.free_set_stale        = free_ff;
   assign rsp.likelihood_stale      = lik_ff;
   assign rsp.occupied_change_count = occ_ff;

   a_dlen_bound: assert property (@(posedge clock) disable iff (reset)
      dlen_ff <= CNT_W'(CELL_STORE))
      else $error("dirty list length beyond cell store");

   a_no_rsp_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_INIT) |-> !rsp_valid_ff)
      else $error("result shown during power-up clear");

   a_calc_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CALC) |-> ($past(state_ff) == BK_READ || $past(state_ff) == BK_CALC))
      else $error("cell update without a preceding memory read");

   a_sweep_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SWEEP) |-> (cnt_ff <= CNT_W'(CELL_STORE)))
      else $error("sweep counter overrun");

endmodule

[rtl/logodds_occupancy_grid_update.sv]
`timescale 1ns / 1ps
// Top level of the log-odds occupancy grid update block.
//
// Commands arrive as words on req_ch and each one yields exactly one word on
// rsp_ch; both are valid/ready channels. Registers are written on csr_ch,
// which is always ready, and should only change while no command is pending.
// The front end checks bounds and computes the cell index with one multiplier,
// then queues the command in a two-word queue. The cell engine behind it owns
// one cell memory with one read and one write port.
// A cell update passes through the engine as dequeue, memory read, then modify
// and write; the engine takes no new command until that result is registered.
// An out-of-grid command skips the memory read and goes straight to its result.
// Map reset and dirty clear sweep the whole cell memory, one entry a cycle.
// After reset the engine clears the cell memory with req_ch.ready low. When
// rsp_ch stalls, the result register holds, the engine waits, and the queue
// keeps taking commands until it is full.
module logodds_occupancy_grid_update
   import ogu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ogu_req_if.sink   req_ch,
   ogu_rsp_if.source rsp_ch,
   ogu_csr_if.sink   csr_ch
);

   cfg_type       cfg_ff, cfg_in;
   logic          q_full;
   logic          init_busy;
   logic          q_push;
   work_type      push_data;
   work_type      pop_data;
   logic          q_valid;
   logic          q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_GRID_COLS: cfg_in.grid_cols = csr_ch.data[8:0];
            REG_GRID_ROWS: cfg_in.grid_rows = csr_ch.data[8:0];
            REG_FLOOR:     cfg_in.floor_lvl = csr_ch.data;
            REG_CEILING:   cfg_in.ceil_lvl  = csr_ch.data;
            REG_OCC_LOCK:  cfg_in.occ_lock  = csr_ch.data;
            REG_FREE_LOCK: cfg_in.free_lock = csr_ch.data;
            REG_FREE_THR:  cfg_in.free_thr  = csr_ch.data;
            REG_OCC_THR:   cfg_in.occ_thr   = csr_ch.data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_cols <= 9'd256;
         cfg_ff.grid_rows <= 9'd256;
         cfg_ff.floor_lvl <= -16'sd1280;
         cfg_ff.ceil_lvl  <= 16'sd1280;
         cfg_ff.occ_lock  <= 16'sd32767;
         cfg_ff.free_lock <= 16'h8000;
         cfg_ff.free_thr  <= -16'sd256;
         cfg_ff.occ_thr   <= 16'sd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ch.ready = 1'b1;

   ogu_front u_front (
      .req       (req_ch),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .init_busy (init_busy),
      .push      (q_push),
      .push_data (push_data)
   );

   ogu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (pop_data)
   );

   ogu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (pop_data),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .rsp       (rsp_ch)
   );

endmodule
